@@ rtl/nfb_pkg.sv @@
// Shared types and constants for the notch filter biquad unit.
package nfb_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WMUL,
    ST_PROD,
    ST_SUMS,
    ST_DIV,
    ST_MAC,
    ST_SAT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    REG_OMEGA = 2'd0,
    REG_PERIOD = 2'd1,
    REG_DNUM = 2'd2,
    REG_DDEN = 2'd3
  } reg_idx_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input word
    logic fill;      // restart: refill history
    logic wmul;      // form w = omega * T
    logic prod;      // one partial product of w*w, w*bd, w*bn
    logic sums;      // form numerators and den
    logic div_start; // start coefficient divider
    logic div_step;  // one divider step
    logic mac;       // one multiply-accumulate step
    logic sat;       // round and saturate
    logic commit;    // shift history (input word and result)
  } cmd_t;

  typedef struct packed {
    logic prod_done;
    logic div_done;
    logic mac_done;
  } sts_t;

endpackage

@@ rtl/nfb_ctrl.sv @@
// Controller state machine of the notch filter biquad unit.
module nfb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_restart_i,
  output logic          in_stall_o,
  input  logic          out_free_i,
  input  nfb_pkg::sts_t sts_i,
  output nfb_pkg::cmd_t cmd_o
);
  import nfb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_restart_i ? ST_WMUL : ST_MAC;
        end
      end
      ST_WMUL: state_d = ST_PROD;
      ST_PROD: if (sts_i.prod_done) state_d = ST_SUMS;
      ST_SUMS: state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_MAC;
      ST_MAC:  if (sts_i.mac_done) state_d = ST_SAT;
      ST_SAT:  state_d = ST_OUT;
      ST_OUT:  if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        cmd_o.fill = in_valid_i & in_restart_i;
      end
      ST_WMUL: cmd_o.wmul = 1'b1;
      ST_PROD: cmd_o.prod = 1'b1;
      ST_SUMS: begin
        cmd_o.sums = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_MAC:  cmd_o.mac = 1'b1;
      ST_SAT:  cmd_o.sat = 1'b1;
      ST_OUT:  cmd_o.commit = out_free_i;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q != ST_IDLE))
    else $error("load did not leave idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SAT) |=> (state_q == ST_OUT))
    else $error("saturate not followed by output");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wmul, cmd_o.prod, cmd_o.mac, cmd_o.sat, cmd_o.commit}))
    else $error("datapath commands overlap");
endmodule

@@ rtl/nfb_datapath.sv @@
// Datapath: coefficient computation, serial divider, shared MAC and saturation.
module nfb_datapath #(
  parameter int SAMPLE_BITS    = 32,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nfb_pkg::cmd_t          cmd_i,
  output nfb_pkg::sts_t          sts_o,
  input  logic [31:0]            omega_i,
  input  logic [31:0]            period_i,
  input  logic [23:0]            dnum_i,
  input  logic [23:0]            dden_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                   use_initial_i,
  input  logic signed [SAMPLE_BITS-1:0] initial_value_i,
  output logic signed [SAMPLE_BITS-1:0] result_o
);
  import nfb_pkg::*;

  localparam int CW  = COEF_FRAC_BITS + 4;
  localparam int NW  = 98;                 // numerator/den magnitude width, Q34.64
  localparam int RW  = NW + 3;             // divider remainder
  localparam int QB  = COEF_FRAC_BITS + 3; // quotient bits
  localparam int PW  = CW + SAMPLE_BITS;   // one product
  localparam int AW  = PW + 3;             // accumulator
  localparam int DCW = $clog2(QB + 1);
  localparam logic [CW-1:0] CMAX = CW'((64'd1 << QB) - 64'd1);

  logic signed [SAMPLE_BITS-1:0] x_q, xh1_q, xh2_q, yh1_q, yh2_q;
  logic signed [SAMPLE_BITS-1:0] hfill;
  logic signed [CW-1:0] c_q [4];
  logic [47:0] w_q;
  logic [95:0] ww_q;
  logic [71:0] wbd_q, wbn_q;
  logic [NW-1:0] den_q;
  logic [2:0]  pcnt_q;
  logic [23:0] pa, pb;
  logic [47:0] pm;

  // w = omega*T >> 16, Q16.32
  logic [63:0] wfull;
  assign wfull = 64'(omega_i) * 64'(period_i);

  // w*w, w*bd, w*bn built from 24x24 partial products, one a cycle.
  always_comb begin
    case (pcnt_q)
      3'd0: begin pa = w_q[23:0];  pb = w_q[23:0];  end
      3'd1: begin pa = w_q[23:0];  pb = w_q[47:24]; end
      3'd2: begin pa = w_q[47:24]; pb = w_q[47:24]; end
      3'd3: begin pa = w_q[23:0];  pb = dden_i;     end
      3'd4: begin pa = w_q[47:24]; pb = dden_i;     end
      3'd5: begin pa = w_q[23:0];  pb = dnum_i;     end
      default: begin pa = w_q[47:24]; pb = dnum_i; end
    endcase
    pm = 48'(pa) * 48'(pb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
    end else if (cmd_i.wmul) begin
      pcnt_q <= '0;
    end else if (cmd_i.prod) begin
      pcnt_q <= (pcnt_q == 3'd6) ? 3'd0 : pcnt_q + 3'd1;
    end
  end
  assign sts_o.prod_done = cmd_i.prod && (pcnt_q == 3'd6);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.wmul) begin
      w_q   <= wfull[63:16];
      ww_q  <= '0;
      wbd_q <= '0;
      wbn_q <= '0;
    end
    if (cmd_i.prod) begin
      case (pcnt_q)
        3'd0: ww_q <= ww_q + 96'(pm);
        3'd1: ww_q <= ww_q + (96'(pm) << 25);   // cross term, twice
        3'd2: ww_q <= ww_q + (96'(pm) << 48);
        3'd3: wbd_q <= wbd_q + 72'(pm);
        3'd4: wbd_q <= wbd_q + (72'(pm) << 24);
        3'd5: wbn_q <= wbn_q + 72'(pm);
        default: wbn_q <= wbn_q + (72'(pm) << 24);
      endcase
    end
  end

  assign hfill = use_initial_i ? initial_value_i : sample_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh1_q <= '0;
      xh2_q <= '0;
      yh1_q <= '0;
      yh2_q <= '0;
    end else if (cmd_i.fill) begin
      xh1_q <= hfill;
      xh2_q <= hfill;
      yh1_q <= hfill;
      yh2_q <= hfill;
    end else if (cmd_i.commit) begin
      xh2_q <= xh1_q;
      xh1_q <= x_q;
      yh2_q <= yh1_q;
      yh1_q <= result_o;
    end
  end

  // Numerators in Q.64 signed (NW+1 bits), den positive.
  logic [NW:0] base, wbd4, wbn4;
  logic [NW:0] n [4];
  logic [NW-1:0] den_c;
  always_comb begin
    base = (NW+1)'(ww_q) + ((NW+1)'(4) << 64);
    wbd4 = (NW+1)'(wbd_q) << 18;
    wbn4 = (NW+1)'(wbn_q) << 18;
    n[0] = base + wbn4;
    n[1] = ((NW+1)'(ww_q) << 1) - ((NW+1)'(8) << 64);
    n[2] = base - wbn4;
    n[3] = base - wbd4;
    den_c = base[NW-1:0] + wbd4[NW-1:0];
  end

  function automatic logic [NW-1:0] absv(input logic [NW:0] v);
    logic [NW:0] t;
    t = v[NW] ? (~v + 1'b1) : v;
    return t[NW-1:0];
  endfunction

  // Restoring divider: four coefficients in parallel lanes, one bit a step.
  // Each step compares the remainder against 4*den, then doubles it.
  logic [DCW-1:0] dcnt_q;
  logic [RW-1:0]  r_q [4];
  logic [QB-1:0]  quo_q [4];
  logic           ovf_q [4];
  logic           nneg_q [4];
  logic [NW-1:0]  nabs [4];
  logic [RW-1:0]  dd;
  assign dd = RW'(den_q) << 2;

  always_comb begin
    for (int i = 0; i < 4; i++) nabs[i] = absv(n[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      for (int i = 0; i < 4; i++) c_q[i] <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dcnt_q == DCW'(QB)) begin
        for (int i = 0; i < 4; i++) begin
          if (ovf_q[i]) c_q[i] <= nneg_q[i] ? -$signed(CMAX) : $signed(CMAX);
          else c_q[i] <= nneg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
        end
      end else begin
        dcnt_q <= dcnt_q + DCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sums) begin
      den_q <= den_c;
      for (int i = 0; i < 4; i++) begin
        r_q[i]    <= RW'(nabs[i]);
        ovf_q[i]  <= RW'(nabs[i]) >= (RW'(den_c) << 3);
        nneg_q[i] <= n[i][NW];
        quo_q[i]  <= '0;
      end
    end else if (cmd_i.div_step && dcnt_q != DCW'(QB)) begin
      for (int i = 0; i < 4; i++) begin
        if (r_q[i] >= dd) begin
          r_q[i]   <= (r_q[i] - dd) << 1;
          quo_q[i] <= {quo_q[i][QB-2:0], 1'b1};
        end else begin
          r_q[i]   <= r_q[i] << 1;
          quo_q[i] <= {quo_q[i][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign sts_o.div_done = (dcnt_q == DCW'(QB));

  // Shared multiplier, five taps one per cycle.
  logic [2:0] mcnt_q;
  logic signed [AW-1:0] acc_q;
  logic signed [CW-1:0] mc;
  logic signed [SAMPLE_BITS-1:0] mx;
  logic signed [PW-1:0] prd;
  always_comb begin
    case (mcnt_q)
      3'd0: begin mc = c_q[0]; mx = x_q; end
      3'd1: begin mc = c_q[1]; mx = xh1_q; end
      3'd2: begin mc = c_q[2]; mx = xh2_q; end
      3'd3: begin mc = -c_q[1]; mx = yh1_q; end
      default: begin mc = -c_q[3]; mx = yh2_q; end
    endcase
    prd = PW'(mc) * PW'(mx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
      acc_q  <= '0;
    end else if (cmd_i.mac) begin
      acc_q  <= ((mcnt_q == 3'd0) ? AW'(1) << (COEF_FRAC_BITS - 1) : acc_q) + AW'(prd);
      mcnt_q <= (mcnt_q == 3'd4) ? 3'd0 : mcnt_q + 1'b1;
    end
  end
  assign sts_o.mac_done = cmd_i.mac && (mcnt_q == 3'd4);

  logic signed [AW-1:0] sh;
  assign sh = acc_q >>> COEF_FRAC_BITS;
  localparam logic signed [AW-1:0] SMAX = AW'((65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1);
  always_ff @(posedge clk_i) begin
    if (cmd_i.sat) begin
      if (sh > SMAX) result_o <= SAMPLE_BITS'(SMAX);
      else if (sh < -SMAX - 1) result_o <= SAMPLE_BITS'(-SMAX - 1);
      else result_o <= SAMPLE_BITS'(sh);
    end
  end
endmodule

@@ rtl/notch_filter_biquad_unit.sv @@
// Top level of the notch filter biquad unit.
// Use: a second-order notch filter over a stream of Q16.16 samples.
// Input channel in_valid_i/in_stall_o carries one word: sample_in_i,
// restart_i, use_initial_i, initial_value_i. Output channel
// out_valid_o/out_stall_i returns one filtered, saturated word per input.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 notch omega, 1 sample period, 2 numerator damping,
// 3 denominator damping. Write only while idle.
// Sequence: a plain word runs five taps on the shared MAC multiplier,
// then rounding; the next word is taken once the result has been
// delivered. A restart word first forms w, then seven partial
// products, then the sums, then runs the bit-serial divider (one
// quotient bit per cycle, four lanes).
// One word is in flight at a time; in_stall_o is high while busy.
// Reset clears the controller, coefficients and history to zero
// (coefficients are zero until the first restart, so output is 0).
// When the receiver stalls, the result holds in the output register and
// the block waits.
module notch_filter_biquad_unit #(
  parameter int SAMPLE_BITS    = 32,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                   restart_i,
  input  logic                   use_initial_i,
  input  logic signed [SAMPLE_BITS-1:0] initial_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import nfb_pkg::*;

  logic [31:0] omega_q, period_q;
  logic [23:0] dnum_q, dden_q;
  cmd_t cmd;
  sts_t sts;
  logic busy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q  <= 32'd65536;
      period_q <= 32'd42949673;
      dnum_q   <= 24'd0;
      dden_q   <= 24'd16384;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_OMEGA:  omega_q  <= cfg_data_i;
        REG_PERIOD: period_q <= cfg_data_i;
        REG_DNUM:   dnum_q   <= cfg_data_i[23:0];
        REG_DDEN:   dden_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  nfb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i   (in_valid_i),
    .in_restart_i (restart_i),
    .in_stall_o   (in_stall_o),
    .out_free_i   (!out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  nfb_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts),
    .omega_i (omega_q), .period_i (period_q), .dnum_i (dnum_q), .dden_i (dden_q),
    .sample_in_i, .use_initial_i, .initial_value_i,
    .result_o (sample_out_o)
  );

  // Output word is valid from rounding until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (cmd.sat) begin
      busy_q <= 1'b1;
    end else if (busy_q && !out_stall_i) begin
      busy_q <= 1'b0;
    end
  end
  assign out_valid_o = busy_q;
endmodule

@@ tb/sv/notch_filter_biquad_unit_tb.sv @@
// Self-checking testbench for the notch filter biquad unit.
module notch_filter_biquad_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nfb_pkg::*;

  // Notch filter scoreboard: keeps its own copy of the config, coefficients and
  // history, predicts each output word and checks it against the block.
  class notch_scoreboard;
    logic [31:0] omega = 32'd65536;
    logic [31:0] period = 32'd42949673;
    logic [23:0] dnum = 24'd0;
    logic [23:0] dden = 24'd16384;
    int x1, x2, y1, y2;
    int c_ff0, c_mid, c_ff2, c_fb2;
    int filtered_q[$];
    int errors;

    // |num| * 2^28 / den, truncated toward zero, saturated to Q3.28
    function int coef_quot(logic signed [127:0] num, logic [127:0] den);
      logic [127:0] m;
      logic [31:0] q;
      m = num[127] ? -num : num;
      if (m >= (den << 3)) q = 32'h7FFF_FFFF;
      else q = 32'((m << 28) / den);
      return num[127] ? -int'(q) : int'(q);
    endfunction

    function void derive_coefs();
      logic [63:0] w;
      logic [127:0] ww, wbd4, wbn4, base, den, four;
      w = ({32'd0, omega} * {32'd0, period}) >> 16;
      four = 128'd4 << 64;
      ww = {64'd0, w} * {64'd0, w};
      wbd4 = ({64'd0, w} * {104'd0, dden}) << 18;
      wbn4 = ({64'd0, w} * {104'd0, dnum}) << 18;
      base = four + ww;
      den = base + wbd4;
      c_ff0 = coef_quot(base + wbn4, den);
      c_mid = coef_quot((ww << 1) - (128'd8 << 64), den);
      c_ff2 = coef_quot(base - wbn4, den);
      c_fb2 = coef_quot(base - wbd4, den);
    endfunction

    function void note_word(int x, bit rs, bit ui, int iv);
      logic signed [127:0] acc, p;
      logic signed [127:0] smax, smin;
      int y;
      smax = 128'sh7FFF_FFFF;
      smin = -128'sh8000_0000;
      if (rs) begin
        x1 = ui ? iv : x;
        x2 = x1; y1 = x1; y2 = x1;
        derive_coefs();
      end
      p = longint'(c_ff0) * longint'(x);  acc = p;
      p = longint'(c_mid) * longint'(x1); acc = acc + p;
      p = longint'(c_ff2) * longint'(x2); acc = acc + p;
      p = longint'(c_mid) * longint'(y1); acc = acc - p;
      p = longint'(c_fb2) * longint'(y2); acc = acc - p;
      acc = (acc + (128'sd1 <<< 27)) >>> 28;
      if (acc > smax) y = 32'h7FFF_FFFF;
      else if (acc < smin) y = 32'h8000_0000;
      else y = int'(acc[31:0]);
      x2 = x1; x1 = x; y2 = y1; y1 = y;
      filtered_q.push_back(y);
    endfunction

    function void check_word(int got);
      int want;
      if (filtered_q.size() == 0) begin
        $error("sample_out: unexpected word %0d", got);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] sample_in_i = '0;
  logic restart_i = 1'b0;
  logic use_initial_i = 1'b0;
  logic signed [31:0] initial_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] sample_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  notch_scoreboard sb = new();
  bit quiet_tail = 1'b0;   // no idling on either side near the end
  int words_sent = 0;

  notch_filter_biquad_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_in_i, .restart_i,
    .use_initial_i, .initial_value_i, .out_valid_o, .out_stall_i, .sample_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitors: both channels sampled at the rising edge, before the block's
  // own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_word(sample_in_i, restart_i, use_initial_i, initial_value_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(sample_out_o);
  end

  // Receiver stall: random bursts, none in the tail.
  initial begin
    forever begin
      if (quiet_tail || $urandom_range(0, 3) != 0) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Drive one word and hold it until taken; valid stays high on return unless a sender gap follows.
  task automatic send_word(int x, bit rs, bit ui, int iv);
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    restart_i <= rs;
    use_initial_i <= ui;
    initial_value_i <= iv;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    // sender gap, now and then
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.filtered_q.size() != 0) @(posedge clk_i);
    // let the block settle back to idle
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_OMEGA:  sb.omega = val;
      REG_PERIOD: sb.period = val;
      REG_DNUM:   sb.dnum = val[23:0];
      default:    sb.dden = val[23:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] om, logic [31:0] per, logic [23:0] bn,
                           logic [23:0] bd);
    write_reg(REG_OMEGA, om);
    write_reg(REG_PERIOD, per);
    write_reg(REG_DNUM, {8'd0, bn});
    write_reg(REG_DDEN, {8'd0, bd});
  endtask

  // Half the time modest signals, else the full range or its extremes.
  function automatic int rand_sample();
    case ($urandom_range(0, 3))
      0: return int'($urandom());
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coefficients still zero before the first restart
    send_word(32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000);
    send_word(32'h8000_0000, 1'b0, 1'b0, 32'h7FFF_FFFF);
    send_word(32'h0001_0000, 1'b0, 1'b0, 0);
    // restart from initial value and from the sample itself
    send_word(32'h0001_0000, 1'b1, 1'b1, 32'h7FFF_FFFF);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b0, 0);
    send_word(32'h8000_0000, 1'b0, 1'b0, 0);
    send_word(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000);
    send_word(0, 1'b0, 1'b0, 0);
    send_word(32'h0002_0000, 1'b1, 1'b0, 32'h1234_5678);
    send_word(-1, 1'b0, 1'b0, 0);
    send_word(1, 1'b0, 1'b0, 0);
    drain();   // hold the sender until every word is back

    // zero sample period: coefficients 1, -2, 1, 1
    write_all(32'hFFFF_FFFF, 32'd0, 24'd0, 24'd0);
    send_word(32'h0001_0000, 1'b1, 1'b1, 0);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b0, 0);
    send_word(32'h8000_0000, 1'b0, 1'b0, 0);
    drain();
    // everything at full scale
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_word(32'h7FFF_FFFF, 1'b1, 1'b0, 0);
    send_word(32'h8000_0000, 1'b0, 1'b0, 0);
    drain();
    write_all(32'd0, 32'd1, 24'hFF_FFFF, 24'd0);
    send_word(32'h0003_0000, 1'b1, 1'b1, 32'hFFFF_0000);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b0, 0);
    drain();

    // Random phases, each under its own setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(32'd65536 * 60, 32'd42949673, 24'h00_1000, 24'h00_8000);
        1: write_all(32'd65536 * 6, 32'd4294967, 24'd0, 24'h00_4000);
        2: write_all($urandom(), $urandom(), 24'($urandom()), 24'($urandom()));
        3: write_all($urandom_range(0, 32'h0100_0000), $urandom_range(1, 32'h1000_0000),
                     24'($urandom_range(0, 32'h3_0000)), 24'($urandom_range(0, 32'h3_0000)));
        4: write_all(32'hFFFF_FFFF, 32'd1, 24'hFF_FFFF, 24'hFF_FFFF);
        5: write_all(32'd0, 32'hFFFF_FFFF, 24'd0, 24'hFF_FFFF);
        default: write_all($urandom_range(0, 32'h0400_0000), $urandom_range(1, 32'h0800_0000),
                           24'($urandom_range(0, 32'h1_0000)),
                           24'($urandom_range(0, 32'h2_0000)));
      endcase
      if (ph == 7) quiet_tail = 1'b1;
      send_word(rand_sample(), 1'b1, $urandom_range(0, 1), int'($urandom()));
      repeat (127) begin
        if ($urandom_range(0, 19) == 0)
          send_word(rand_sample(), 1'b1, $urandom_range(0, 1), int'($urandom()));
        else
          send_word(rand_sample(), 1'b0, $urandom_range(0, 1), int'($urandom()));
      end
      drain();
    end

    if (sb.errors == 0)
      $display("notch_filter_biquad_unit verification clean");
    else
      $display("notch_filter_biquad_unit verification failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("notch_filter_biquad_unit verification failed");
    $finish;
  end

endmodule
